// ===== hw/rtl/bmx_pkg.sv =====
package bmx_pkg;

  localparam logic [7:0] OpXba = 8'hEB;
  localparam logic [7:0] OpWdm = 8'h42;
  localparam logic [7:0] OpMvp = 8'h44;
  localparam logic [7:0] OpMvn = 8'h54;

  localparam logic [15:0] AccDone = 16'hFFFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_REG   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_UNSUP = 2'd3
  } kind_e;

  typedef enum logic {
    CMD_EXEC  = 1'b0,
    CMD_RDATA = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  opcode;
    logic [15:0] acc_in;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [7:0]  data_bank_in;
    logic [7:0]  operand_dest_bank;
    logic [7:0]  operand_src_bank;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] mem_address;
    logic [7:0]  write_data;
    logic [15:0] acc_out;
    logic [15:0] x_out;
    logic [15:0] y_out;
    logic [7:0]  bank_out;
    logic [1:0]  pc_step;
    logic        flags_valid;
    logic        neg_flag;
    logic        zero_flag;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage

// ===== hw/rtl/block_move_exchange_unit.sv =====
// Each result beat is registered in the result queue and offered from there.
// Throughput: one input beat per cycle while the result queue has room; a
// read-data beat during a move yields two result beats, so the single output
// port of the queue sets the sustained rate at one result beat per cycle.
// Reset: asynchronous, active low; clears the move state and empties the queue.
module block_move_exchange_unit
  import bmx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  opcode_i,
  input  logic [15:0] acc_in_i,
  input  logic [15:0] index_x_i,
  input  logic [15:0] index_y_i,
  input  logic [7:0]  data_bank_in_i,
  input  logic [7:0]  operand_dest_bank_i,
  input  logic [7:0]  operand_src_bank_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [23:0] mem_address_o,
  output logic [7:0]  write_data_o,
  output logic [15:0] acc_out_o,
  output logic [15:0] x_out_o,
  output logic [15:0] y_out_o,
  output logic [7:0]  bank_out_o,
  output logic [1:0]  pc_step_o,
  output logic        flags_valid_o,
  output logic        neg_flag_o,
  output logic        zero_flag_o,
  output logic        last_o
);

  in_item_t item;
  push_t    push;
  res_t     res;
  logic     room;
  logic     fire;

  assign item = '{
    cmd:               cmd_i,
    opcode:            opcode_i,
    acc_in:            acc_in_i,
    index_x:           index_x_i,
    index_y:           index_y_i,
    data_bank_in:      data_bank_in_i,
    operand_dest_bank: operand_dest_bank_i,
    operand_src_bank:  operand_src_bank_i,
    read_data:         read_data_i
  };

  assign in_ready_o = room;
  assign fire       = in_valid_i && room;

  bmx_exec u_exec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .push_o (push)
  );

  bmx_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res)
  );

  assign kind_o        = res.kind;
  assign mem_address_o = res.mem_address;
  assign write_data_o  = res.write_data;
  assign acc_out_o     = res.acc_out;
  assign x_out_o       = res.x_out;
  assign y_out_o       = res.y_out;
  assign bank_out_o    = res.bank_out;
  assign pc_step_o     = res.pc_step;
  assign flags_valid_o = res.flags_valid;
  assign neg_flag_o    = res.neg_flag;
  assign zero_flag_o   = res.zero_flag;
  assign last_o        = res.last;

endmodule

// ===== hw/rtl/bmx_exec.sv =====
module bmx_exec
  import bmx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  logic        moving_q, moving_d;
  logic        desc_q, desc_d;
  logic [7:0]  src_bank_q, src_bank_d;
  logic [7:0]  dst_bank_q, dst_bank_d;
  logic [15:0] src_off_q, src_off_d;
  logic [15:0] dst_off_q, dst_off_d;
  logic [15:0] remain_q, remain_d;

  logic [15:0] src_next;
  logic [15:0] dst_next;
  logic [7:0]  swap_lo;
  res_t        r0, r1;

  assign src_next = desc_q ? src_off_q - 16'd1 : src_off_q + 16'd1;
  assign dst_next = desc_q ? dst_off_q - 16'd1 : dst_off_q + 16'd1;
  assign swap_lo  = item_i.acc_in[15:8];

  always_comb begin
    moving_d   = moving_q;
    desc_d     = desc_q;
    src_bank_d = src_bank_q;
    dst_bank_d = dst_bank_q;
    src_off_d  = src_off_q;
    dst_off_d  = dst_off_q;
    remain_d   = remain_q;
    r0         = '0;
    r1         = '0;
    push_o     = '0;

    if (item_i.cmd == CMD_EXEC) begin
      moving_d       = 1'b0;
      push_o.count   = 2'd1;
      r0.last        = 1'b1;
      r0.acc_out     = item_i.acc_in;
      r0.x_out       = item_i.index_x;
      r0.y_out       = item_i.index_y;
      r0.bank_out    = item_i.data_bank_in;
      case (item_i.opcode)
        OpXba: begin
          r0.kind        = KIND_REG;
          r0.acc_out     = {item_i.acc_in[7:0], swap_lo};
          r0.pc_step     = 2'd1;
          r0.flags_valid = 1'b1;
          r0.neg_flag    = swap_lo[7];
          r0.zero_flag   = (swap_lo == 8'd0);
        end
        OpWdm: begin
          r0.kind    = KIND_REG;
          r0.pc_step = 2'd2;
        end
        OpMvp, OpMvn: begin
          moving_d       = 1'b1;
          desc_d         = (item_i.opcode == OpMvp);
          src_bank_d     = item_i.operand_src_bank;
          dst_bank_d     = item_i.operand_dest_bank;
          src_off_d      = item_i.index_x;
          dst_off_d      = item_i.index_y;
          remain_d       = item_i.acc_in;
          r0             = '0;
          r0.kind        = KIND_READ;
          r0.mem_address = {item_i.operand_src_bank, item_i.index_x};
          r0.last        = 1'b1;
        end
        default: begin
          r0.kind = KIND_UNSUP;
        end
      endcase
    end else if (moving_q) begin
      push_o.count   = 2'd2;
      r0.kind        = KIND_WRITE;
      r0.mem_address = {dst_bank_q, dst_off_q};
      r0.write_data  = item_i.read_data;
      src_off_d      = src_next;
      dst_off_d      = dst_next;
      r1.last        = 1'b1;
      if (remain_q == 16'd0) begin
        moving_d    = 1'b0;
        r1.kind     = KIND_REG;
        r1.acc_out  = AccDone;
        r1.x_out    = src_next;
        r1.y_out    = dst_next;
        r1.bank_out = dst_bank_q;
        r1.pc_step  = 2'd3;
      end else begin
        remain_d       = remain_q - 16'd1;
        r1.kind        = KIND_READ;
        r1.mem_address = {src_bank_q, src_next};
      end
    end
    push_o.res0 = r0;
    push_o.res1 = r1;
    if (!fire_i) begin
      push_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q   <= 1'b0;
      desc_q     <= 1'b0;
      src_bank_q <= '0;
      dst_bank_q <= '0;
      src_off_q  <= '0;
      dst_off_q  <= '0;
      remain_q   <= '0;
    end else if (fire_i) begin
      moving_q   <= moving_d;
      desc_q     <= desc_d;
      src_bank_q <= src_bank_d;
      dst_bank_q <= dst_bank_d;
      src_off_q  <= src_off_d;
      dst_off_q  <= dst_off_d;
      remain_q   <= remain_d;
    end
  end

endmodule

// ===== hw/rtl/bmx_result_fifo.sv =====
module bmx_result_fifo
  import bmx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic [QueuePtrW-1:0] wr_ptr_nx;
  logic                 pop;

  assign valid_o   = (count_q != '0);
  assign room_o    = (count_q <= QueueCntW'(QueueDepth - 2));
  assign pop       = valid_o && ready_i;
  assign data_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + QueuePtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QueuePtrW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q + QueueCntW'(push_i.count) - QueueCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/bmx_checker.sv =====
module bmx_checker
  import bmx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [23:0] mem_address_o,
  input logic [1:0]  pc_step_o,
  input logic        flags_valid_o,
  input logic        neg_flag_o,
  input logic        zero_flag_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(mem_address_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_WRITE |-> !last_o)
    else $error("write beat marked last");

  a_mem_no_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_READ || kind_o == KIND_WRITE)
      |-> pc_step_o == 2'd0 && !flags_valid_o)
    else $error("memory request carries register fields");

  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !flags_valid_o |-> !neg_flag_o && !zero_flag_o)
    else $error("flags set without flags_valid");

endmodule

bind block_move_exchange_unit bmx_checker u_bmx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .mem_address_o (mem_address_o),
  .pc_step_o     (pc_step_o),
  .flags_valid_o (flags_valid_o),
  .neg_flag_o    (neg_flag_o),
  .zero_flag_o   (zero_flag_o),
  .last_o        (last_o)
);
